@@ sv/mads_pkg.sv @@
package mads_pkg;

   localparam int BYTE_W   = 8;
   localparam int BYTE_MAX = 255;
   localparam int ACT_W    = 2;
   localparam int OUT_W    = 17;

   localparam logic [OUT_W-1:0] COST_SAT = 17'h1FFFF;

   localparam logic [ACT_W-1:0] ACT_FIRST   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_SECOND  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROW_RD,
      ST_ROW_HEAD,
      ST_CELL,
      ST_FIN_RD,
      ST_OUT
   } state_type;

endpackage

@@ sv/mads_ram.sv @@
module mads_ram #(
   parameter int DEPTH  = 256,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/mads_cell.sv @@
module mads_cell
   import mads_pkg::*;
#(
   parameter int COST_W = 17
) (
   input  logic [BYTE_W-1:0] a,
   input  logic [BYTE_W-1:0] b,
   input  logic [COST_W-1:0] above,
   input  logic [COST_W-1:0] right,
   input  logic [COST_W-1:0] diag,
   output logic [COST_W-1:0] next_cost
);

   logic [COST_W-1:0] drop_first;
   logic [COST_W-1:0] drop_second;

   always_comb begin
      drop_first  = COST_W'(a) + above;
      drop_second = COST_W'(b) + right;
      if (a == b) begin
         next_cost = diag;
      end else if (drop_first < drop_second) begin
         next_cost = drop_first;
      end else begin
         next_cost = drop_second;
      end
   end

endmodule

@@ sv/min_ascii_delete_sum_core.sv @@
// Minimum ASCII delete-sum engine. Action 0 and 1 items append one byte to the first or
// second string (up to MAX_LEN each; further bytes are dropped and raise the overflow flag),
// one per cycle while no compute runs. An action 2 item runs the edit table over a single
// cost row held in a one-read, one-write memory and returns one result; action 3 is ignored.
// A compute fills the cost row with suffix sums of the second string (ST_INIT), then takes
// each byte of the first string, last first, through ST_ROW_RD, ST_ROW_HEAD and ST_CELL,
// and registers the result through ST_FIN_RD and ST_OUT. The row memory's single read port
// sets the pace at one table cell per cycle, after the row head is fetched for each row.
// Lengths and the overflow flag clear when the result is produced. A new compute is held
// off until the previous result has been transferred; appends are taken while it waits.
module min_ascii_delete_sum_core
   import mads_pkg::*;
#(
   parameter int MAX_LEN = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [ACT_W-1:0]  req_action,
   input  logic [BYTE_W-1:0] req_byte_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [OUT_W-1:0]  rsp_min_cost,
   output logic              rsp_overflow
);

   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int COST_W = $clog2(2 * BYTE_MAX * MAX_LEN + 1);
   localparam int SUM_W  = (COST_W > OUT_W) ? COST_W : OUT_W;

   state_type state_ff, state_in;
   logic [LEN_W-1:0] first_len_ff, first_len_in;
   logic [LEN_W-1:0] second_len_ff, second_len_in;
   logic ovf_ff, ovf_in;
   logic [LEN_W-1:0] i_ff, i_in;
   logic [LEN_W-1:0] rd_j_ff, rd_j_in;
   logic pv_ff, pv_in;
   logic [LEN_W-1:0] pj_ff, pj_in;
   logic [BYTE_W-1:0] a_ff, a_in;
   logic [COST_W-1:0] diag_ff, diag_in;
   logic [COST_W-1:0] right_ff, right_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] rsp_cost_ff, rsp_cost_in;
   logic rsp_ovf_ff, rsp_ovf_in;

   logic accept;
   logic [LEN_W-1:0] rd_idx;
   logic [LEN_W-1:0] pj_idx;
   logic [LEN_W-1:0] i_idx;
   logic [COST_W-1:0] sum_w;
   logic [COST_W-1:0] cell_next;
   logic [SUM_W-1:0] cost_wide;

   logic              s1_wr_en, s2_wr_en, row_wr_en;
   logic [IDX_W-1:0]  s1_wr_addr, s2_wr_addr, s1_rd_addr, s2_rd_addr;
   logic [BYTE_W-1:0] s1_rdata, s2_rdata;
   logic [LEN_W-1:0]  row_wr_addr, row_rd_addr;
   logic [COST_W-1:0] row_wr_data, row_rdata;

   mads_ram #(.DEPTH(MAX_LEN), .WIDTH(BYTE_W), .ADDR_W(IDX_W)) u_first_ram (
      .clock   (clock),
      .wr_en   (s1_wr_en),
      .wr_addr (s1_wr_addr),
      .wr_data (req_byte_value),
      .rd_addr (s1_rd_addr),
      .rd_data (s1_rdata)
   );

   mads_ram #(.DEPTH(MAX_LEN), .WIDTH(BYTE_W), .ADDR_W(IDX_W)) u_second_ram (
      .clock   (clock),
      .wr_en   (s2_wr_en),
      .wr_addr (s2_wr_addr),
      .wr_data (req_byte_value),
      .rd_addr (s2_rd_addr),
      .rd_data (s2_rdata)
   );

   mads_ram #(.DEPTH(MAX_LEN + 1), .WIDTH(COST_W), .ADDR_W(LEN_W)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (row_wr_data),
      .rd_addr (row_rd_addr),
      .rd_data (row_rdata)
   );

   mads_cell #(.COST_W(COST_W)) u_cell (
      .a         (a_ff),
      .b         (s2_rdata),
      .above     (row_rdata),
      .right     (right_ff),
      .diag      (diag_ff),
      .next_cost (cell_next)
   );

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || req_action != ACT_COMPUTE);
   assign accept    = req_valid && req_ready;
   assign rd_idx    = rd_j_ff - LEN_W'(1);
   assign pj_idx    = pj_ff - LEN_W'(1);
   assign i_idx     = i_ff - LEN_W'(1);
   assign cost_wide = SUM_W'(row_rdata);

   always_comb begin
      state_in      = state_ff;
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      ovf_in        = ovf_ff;
      i_in          = i_ff;
      rd_j_in       = rd_j_ff;
      pv_in         = pv_ff;
      pj_in         = pj_ff;
      a_in          = a_ff;
      diag_in       = diag_ff;
      right_in      = right_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_cost_in   = rsp_cost_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      sum_w         = right_ff + COST_W'(s2_rdata);

      s1_wr_en    = 1'b0;
      s1_wr_addr  = first_len_ff[IDX_W-1:0];
      s2_wr_en    = 1'b0;
      s2_wr_addr  = second_len_ff[IDX_W-1:0];
      s1_rd_addr  = i_idx[IDX_W-1:0];
      s2_rd_addr  = rd_idx[IDX_W-1:0];
      row_wr_en   = 1'b0;
      row_wr_addr = pj_idx;
      row_wr_data = cell_next;
      row_rd_addr = rd_idx;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_FIRST: begin
                     if (first_len_ff < LEN_W'(MAX_LEN)) begin
                        s1_wr_en     = 1'b1;
                        first_len_in = first_len_ff + LEN_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  ACT_SECOND: begin
                     if (second_len_ff < LEN_W'(MAX_LEN)) begin
                        s2_wr_en      = 1'b1;
                        second_len_in = second_len_ff + LEN_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  ACT_COMPUTE: begin
                     // row for an exhausted first string ends in zero
                     row_wr_en   = 1'b1;
                     row_wr_addr = second_len_ff;
                     row_wr_data = '0;
                     rd_j_in     = second_len_ff;
                     pv_in       = 1'b0;
                     right_in    = '0;
                     i_in        = first_len_ff;
                     state_in    = ST_INIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT: begin
            // suffix sums of the second string; right_ff is the running sum
            if (rd_j_ff != '0) begin
               rd_j_in = rd_idx;
               pv_in   = 1'b1;
               pj_in   = rd_j_ff;
            end else begin
               pv_in = 1'b0;
            end
            if (pv_ff) begin
               row_wr_en   = 1'b1;
               row_wr_data = sum_w;
               right_in    = sum_w;
            end
            if (rd_j_ff == '0 && !pv_ff) begin
               state_in = (i_ff == '0) ? ST_FIN_RD : ST_ROW_RD;
            end
         end
         ST_ROW_RD: begin
            row_rd_addr = second_len_ff;
            state_in    = ST_ROW_HEAD;
         end
         ST_ROW_HEAD: begin
            a_in        = s1_rdata;
            diag_in     = row_rdata;
            right_in    = COST_W'(s1_rdata) + row_rdata;
            row_wr_en   = 1'b1;
            row_wr_addr = second_len_ff;
            row_wr_data = COST_W'(s1_rdata) + row_rdata;
            rd_j_in     = second_len_ff;
            pv_in       = 1'b0;
            state_in    = ST_CELL;
         end
         ST_CELL: begin
            // read of j-1 never hits the entry being written (j); new right value is forwarded
            if (rd_j_ff != '0) begin
               rd_j_in = rd_idx;
               pv_in   = 1'b1;
               pj_in   = rd_j_ff;
            end else begin
               pv_in = 1'b0;
            end
            if (pv_ff) begin
               row_wr_en = 1'b1;
               diag_in   = row_rdata;
               right_in  = cell_next;
            end
            if (rd_j_ff == '0 && !pv_ff) begin
               i_in     = i_idx;
               state_in = (i_ff == LEN_W'(1)) ? ST_FIN_RD : ST_ROW_RD;
            end
         end
         ST_FIN_RD: begin
            row_rd_addr = '0;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid_in  = 1'b1;
            rsp_cost_in   = (cost_wide > SUM_W'(COST_SAT)) ? COST_SAT : cost_wide[OUT_W-1:0];
            rsp_ovf_in    = ovf_ff;
            first_len_in  = '0;
            second_len_in = '0;
            ovf_in        = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_len_ff  <= '0;
         second_len_ff <= '0;
         ovf_ff        <= 1'b0;
         i_ff          <= '0;
         rd_j_ff       <= '0;
         pv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         ovf_ff        <= ovf_in;
         i_ff          <= i_in;
         rd_j_ff       <= rd_j_in;
         pv_ff         <= pv_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pj_ff       <= pj_in;
      a_ff        <= a_in;
      diag_ff     <= diag_in;
      right_ff    <= right_in;
      rsp_cost_ff <= rsp_cost_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_min_cost = rsp_cost_ff;
   assign rsp_overflow = rsp_ovf_ff;

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      first_len_ff <= LEN_W'(MAX_LEN) && second_len_ff <= LEN_W'(MAX_LEN))
      else $error("string length past MAX_LEN");

   a_compute_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_action == ACT_COMPUTE |-> !rsp_valid_ff ##1 state_ff == ST_INIT)
      else $error("compute transfer with result pending or without table walk");

   a_pipe_index: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> pj_ff != '0 && pj_ff <= second_len_ff)
      else $error("row write index out of range");

   a_row_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROW_RD |-> i_ff != '0 && i_ff <= first_len_ff)
      else $error("row counter out of range");

   a_out_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |=> rsp_valid_ff && first_len_ff == '0 && second_len_ff == '0 && !ovf_ff)
      else $error("result not posted or lengths not cleared");

endmodule
